>>> rtl/s2d_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes and the pipeline item type used by all files.
// Has no dependencies.
package s2d_pkg;

  localparam int MAG_W = 32;
  localparam int DIGIT_W = 4;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W = BCD_DIGITS * DIGIT_W;
  localparam int IDX_W = $clog2(BCD_DIGITS);
  localparam int STEP_BITS = 4;
  localparam int DD_STAGES = MAG_W / STEP_BITS;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'd57;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ = 4'd3;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [BCD_W-1:0] bcd;
  } s2d_item_t;

endpackage

>>> rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text converter, top level.
// Instantiates s2d_dabble_stage and s2d_serializer; depends on s2d_pkg.
//
// The input channel (in_valid_i, in_stall_o, value_i) takes one signed
// integer per transaction. The output channel (out_valid_o, out_stall_i,
// character_o, last_char_o) gives its decimal text, one character per
// transaction, most significant first, with a leading minus sign for
// negative values and last_char_o set on the final character.
// An accepted value passes an input register that forms the magnitude,
// eight conversion stages of four bits each, the serializer and the output
// register. The pipeline takes a new value every cycle while it has room.
// The output channel sets the throughput: a value takes one output
// transaction per character, from one for a single digit to 11 for the
// most negative value.
// Reset empties all stages and the output register. When the receiver
// stalls, the output register holds its character, the serializer waits
// and the stages fill up before in_stall_o is raised.
module signed_int_to_decimal_ascii import s2d_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [MAG_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CHAR_W-1:0]       character_o,
  output logic                    last_char_o
);

  logic                  pipe_v [DD_STAGES+1];
  s2d_item_t             pipe   [DD_STAGES+1];
  logic [DD_STAGES:0]    en;
  logic                  ser_ready;
  logic                  in_v_q;
  s2d_item_t             in_q;
  s2d_item_t             in_d;

  always_comb begin
    en[DD_STAGES] = !pipe_v[DD_STAGES] || ser_ready;
    for (int k = DD_STAGES - 1; k >= 0; k--) begin
      en[k] = !pipe_v[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_comb begin
    in_d.neg = value_i[MAG_W-1];
    in_d.mag = value_i[MAG_W-1] ? (MAG_W'(0) - MAG_W'(value_i)) : MAG_W'(value_i);
    in_d.bcd = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en[0]) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      in_q <= in_d;
    end
  end

  assign pipe_v[0] = in_v_q;
  assign pipe[0] = in_q;

  for (genvar g = 0; g < DD_STAGES; g++) begin : g_stage
    s2d_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[g+1]),
      .valid_i (pipe_v[g]),
      .item_i  (pipe[g]),
      .valid_o (pipe_v[g+1]),
      .item_o  (pipe[g+1])
    );
  end

  s2d_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pipe_v[DD_STAGES]),
    .item_i      (pipe[DD_STAGES]),
    .ready_o     (ser_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

`ifndef SYNTHESIS
  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == CHAR_MINUS) ||
                    ((character_o >= CHAR_ZERO) && (character_o <= CHAR_NINE)))
    else $error("Output character is neither a minus sign nor a digit.");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (character_o == CHAR_MINUS)) |-> !last_char_o)
    else $error("Minus sign flagged as the last character.");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_v[0] |-> !in_stall_o)
    else $error("Input stalled while the input stage is empty.");
`endif

endmodule

>>> rtl/s2d_dabble_stage.sv
// One register stage of the shift-and-add-3 binary to BCD conversion.
// Consumes STEP_BITS magnitude bits per stage; depends on s2d_pkg.
module s2d_dabble_stage import s2d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  s2d_item_t item_i,
  output logic      valid_o,
  output s2d_item_t item_o
);

  logic      valid_q;
  s2d_item_t item_q;
  s2d_item_t item_d;

  always_comb begin
    logic [MAG_W-1:0] mag;
    logic [BCD_W-1:0] bcd;
    mag = item_i.mag;
    bcd = item_i.bcd;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN) begin
          bcd[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
        end
      end
      bcd = {bcd[BCD_W-2:0], mag[MAG_W-1]};
      mag = {mag[MAG_W-2:0], 1'b0};
    end
    item_d.neg = item_i.neg;
    item_d.mag = mag;
    item_d.bcd = bcd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o = item_q;

endmodule

>>> rtl/s2d_serializer.sv
// Serializer that emits the sign and the significant BCD digits as ASCII,
// one character per cycle unless stalled, through an output register; depends on s2d_pkg.
module s2d_serializer import s2d_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  s2d_item_t         item_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] character_o,
  output logic              last_char_o
);

  logic              busy_q, busy_d;
  logic              minus_q, minus_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [BCD_W-1:0]  bcd_q;
  logic              oval_q, oval_d;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;

  logic              out_free;
  logic              emit;
  logic              done;
  logic              take;
  logic [IDX_W-1:0]  top_idx;
  logic [DIGIT_W-1:0] digit;
  logic [CHAR_W-1:0] emit_char;
  logic              emit_last;

  assign out_free = !oval_q || !out_stall_i;
  assign emit = busy_q && out_free;
  assign done = emit && !minus_q && (idx_q == '0);
  assign ready_o = !busy_q || done;
  assign take = in_valid_i && ready_o;

  always_comb begin
    top_idx = '0;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (item_i.bcd[k*DIGIT_W +: DIGIT_W] != '0) begin
        top_idx = IDX_W'(k);
      end
    end
  end

  always_comb begin
    digit = bcd_q[{idx_q, 2'b00} +: DIGIT_W];
    if (digit > DIGIT_MAX) begin
      digit = DIGIT_MAX;
    end
    if (minus_q) begin
      emit_char = CHAR_MINUS;
      emit_last = 1'b0;
    end else begin
      emit_char = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
      emit_last = (idx_q == '0);
    end
  end

  always_comb begin
    busy_d = busy_q;
    minus_d = minus_q;
    idx_d = idx_q;
    if (emit) begin
      if (minus_q) begin
        minus_d = 1'b0;
      end else if (idx_q == '0) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q - 1'b1;
      end
    end
    if (take) begin
      busy_d = 1'b1;
      minus_d = item_i.neg;
      idx_d = top_idx;
    end
    oval_d = out_free ? emit : oval_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      minus_q <= 1'b0;
      idx_q <= '0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      minus_q <= minus_d;
      idx_q <= idx_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      bcd_q <= item_i.bcd;
    end
    if (emit) begin
      char_q <= emit_char;
      last_q <= emit_last;
    end
  end

  assign out_valid_o = oval_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

endmodule
